// ----- hw/rtl/vtpd_pkg.sv -----
// Shared constants, types and helpers for the vertex transform block.
`timescale 1ns / 1ps
package vtpd_pkg;
	localparam int FRAC_BITS     = 16;
	localparam int NEAR_ZERO_EPS = 66;
	localparam int NUM_REGS      = 8;
	localparam int CFG_IDX_W     = 4;
	localparam int PROD_W        = 64;
	localparam int TRUNC_W       = PROD_W - FRAC_BITS;
	localparam int SUM_W         = TRUNC_W + 2;
	localparam int NUM_W         = 32 + FRAC_BITS;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_W    = 2;
	localparam int FIFO_CNT_W    = 3;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] w;
		logic               do_div;
		logic               sat;
	} vtpd_item_t;

	typedef struct packed {
		logic [31:0] val;
		logic        sat;
	} sat_res_t;

	function automatic sat_res_t sat32(input logic signed [SUM_W-1:0] v);
		sat_res_t r;
		if (v > $signed(SUM_W'(32'sh7fffffff))) begin
			r.val = 32'h7fffffff;
			r.sat = 1'b1;
		end else if (v < $signed({{(SUM_W-32){1'b1}}, 32'h80000000})) begin
			r.val = 32'h80000000;
			r.sat = 1'b1;
		end else begin
			r.val = v[31:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction
endpackage

// ----- hw/rtl/vtpd_in_if.sv -----
// Point input channel.
`timescale 1ns / 1ps
interface vtpd_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] in_x;
	logic signed [31:0] in_y;
	logic signed [31:0] in_z;
	logic signed [31:0] in_w;
	logic               apply_divide;
	modport source (output valid, in_x, in_y, in_z, in_w, apply_divide, input ready);
	modport sink (input valid, in_x, in_y, in_z, in_w, apply_divide, output ready);
endinterface

// ----- hw/rtl/vtpd_out_if.sv -----
// Result output channel.
`timescale 1ns / 1ps
interface vtpd_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic               divided;
	logic               saturated;
	modport source (output valid, out_x, out_y, out_z, divided, saturated, input ready);
	modport sink (input valid, out_x, out_y, out_z, divided, saturated, output ready);
endinterface

// ----- hw/rtl/vtpd_cfg_if.sv -----
// Configuration write channel.
`timescale 1ns / 1ps
interface vtpd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [vtpd_pkg::CFG_IDX_W-1:0] index;
	logic [63:0]                     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/vtpd_front.sv -----
// Front: matrix registers, multiply and sum stages, divide classification.
`timescale 1ns / 1ps
module vtpd_front (
	input  logic                              clk,
	input  logic                              arst_n,
	vtpd_in_if.sink                           pt_in,
	vtpd_cfg_if.sink                          cfg,
	input  logic [vtpd_pkg::FIFO_CNT_W-1:0]   fifo_level,
	output logic                              push,
	output vtpd_pkg::vtpd_item_t              push_item
);
	logic [63:0]                        m_q [vtpd_pkg::NUM_REGS];
	logic signed [vtpd_pkg::PROD_W-1:0] prod_s1 [4][4];
	logic                               div_s1;
	logic                               v_s1;
	vtpd_pkg::vtpd_item_t               item_s2;
	logic                               v_s2;
	vtpd_pkg::vtpd_item_t               item_d;
	logic [vtpd_pkg::FIFO_CNT_W-1:0]    used;
	logic                               acc;

	assign cfg.ready = 1'b1;
	assign used = fifo_level + vtpd_pkg::FIFO_CNT_W'(v_s1) + vtpd_pkg::FIFO_CNT_W'(v_s2);
	assign pt_in.ready = used < vtpd_pkg::FIFO_CNT_W'(vtpd_pkg::FIFO_DEPTH);
	assign acc = pt_in.valid && pt_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q[0] <= 64'h0000000000010000;
			m_q[1] <= 64'h0;
			m_q[2] <= 64'h0001000000000000;
			m_q[3] <= 64'h0;
			m_q[4] <= 64'h0;
			m_q[5] <= 64'h0000000000010000;
			m_q[6] <= 64'h0;
			m_q[7] <= 64'h0001000000000000;
		end else if (cfg.valid && !cfg.index[vtpd_pkg::CFG_IDX_W-1]) begin
			m_q[cfg.index[vtpd_pkg::CFG_IDX_W-2:0]] <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
		end
	end

	logic signed [31:0] vin [4];
	assign vin[0] = pt_in.in_x;
	assign vin[1] = pt_in.in_y;
	assign vin[2] = pt_in.in_z;
	assign vin[3] = pt_in.in_w;

	always_ff @(posedge clk) begin
		if (acc) begin
			div_s1 <= pt_in.apply_divide;
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					prod_s1[r][c] <= vin[r] * $signed(m_q[r*2 + c/2][(c%2)*32 +: 32]);
				end
			end
		end
	end

	always_comb begin
		logic signed [vtpd_pkg::SUM_W-1:0] sum;
		vtpd_pkg::sat_res_t                sr [4];
		logic [31:0]                       aw;
		for (int c = 0; c < 4; c++) begin
			sum = '0;
			for (int r = 0; r < 4; r++) begin
				sum = sum + vtpd_pkg::SUM_W'(
					$signed(prod_s1[r][c][vtpd_pkg::PROD_W-1:vtpd_pkg::FRAC_BITS]));
			end
			sr[c] = vtpd_pkg::sat32(sum);
		end
		aw = vtpd_pkg::mag32(sr[3].val);
		item_d.x      = sr[0].val;
		item_d.y      = sr[1].val;
		item_d.z      = sr[2].val;
		item_d.w      = sr[3].val;
		item_d.do_div = div_s1 && (aw > 32'(vtpd_pkg::NEAR_ZERO_EPS));
		item_d.sat    = sr[0].sat || sr[1].sat || sr[2].sat || (div_s1 && sr[3].sat);
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			item_s2 <= item_d;
		end
	end

	assign push      = v_s2;
	assign push_item = item_s2;
endmodule

// ----- hw/rtl/vtpd_fifo.sv -----
// Short queue between front and back.
`timescale 1ns / 1ps
module vtpd_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  vtpd_pkg::vtpd_item_t            push_item,
	input  logic                            pop,
	output logic                            empty,
	output vtpd_pkg::vtpd_item_t            head,
	output logic [vtpd_pkg::FIFO_CNT_W-1:0] level
);
	vtpd_pkg::vtpd_item_t                mem_q [vtpd_pkg::FIFO_DEPTH];
	logic [vtpd_pkg::FIFO_PTR_W-1:0]     wr_q;
	logic [vtpd_pkg::FIFO_PTR_W-1:0]     rd_q;
	logic [vtpd_pkg::FIFO_CNT_W-1:0]     cnt_q;

	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];
	assign level = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + vtpd_pkg::FIFO_CNT_W'(push) - vtpd_pkg::FIFO_CNT_W'(pop);
		end
	end
endmodule

// ----- hw/rtl/vtpd_back.sv -----
// Back: pipelined radix-2 divider for three lanes and the output register.
`timescale 1ns / 1ps
module vtpd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  vtpd_pkg::vtpd_item_t head,
	output logic                 pop,
	vtpd_out_if.source           res_out
);
	localparam int NS = vtpd_pkg::NUM_W;

	typedef struct packed {
		logic                     do_div;
		logic                     sat;
		logic [31:0]              dv;
		logic                     wneg;
		logic [2:0][31:0]         val;
		logic [2:0][NS-1:0]       num;
		logic [2:0][31:0]         rem;
	} stage_t;

	stage_t st_q [NS+1];
	logic   sv_q [NS+1];
	stage_t st_d [NS+1];
	logic   adv;

	assign adv = !res_out.valid || res_out.ready;
	assign pop = adv && !empty;

	always_comb begin
		logic [31:0] vals [3];
		vals[0] = head.x;
		vals[1] = head.y;
		vals[2] = head.z;
		st_d[0].do_div = head.do_div;
		st_d[0].sat    = head.sat;
		st_d[0].dv     = vtpd_pkg::mag32(head.w);
		st_d[0].wneg   = head.w[31];
		for (int l = 0; l < 3; l++) begin
			st_d[0].val[l] = vals[l];
			st_d[0].num[l] = {vtpd_pkg::mag32(vals[l]), {vtpd_pkg::FRAC_BITS{1'b0}}};
			st_d[0].rem[l] = '0;
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_step
		always_comb begin
			logic [32:0] r2;
			st_d[i+1] = st_q[i];
			for (int l = 0; l < 3; l++) begin
				r2 = {st_q[i].rem[l], st_q[i].num[l][NS-1]};
				if (r2 >= {1'b0, st_q[i].dv}) begin
					st_d[i+1].rem[l] = 32'(r2 - {1'b0, st_q[i].dv});
					st_d[i+1].num[l] = {st_q[i].num[l][NS-2:0], 1'b1};
				end else begin
					st_d[i+1].rem[l] = r2[31:0];
					st_d[i+1].num[l] = {st_q[i].num[l][NS-2:0], 1'b0};
				end
			end
		end
	end

	for (genvar i = 0; i <= NS; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_q[i] <= 1'b0;
			end else if (adv) begin
				sv_q[i] <= (i == 0) ? pop : sv_q[i-((i == 0) ? 0 : 1)];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				st_q[i] <= st_d[i];
			end
		end
	end

	logic [31:0] fin [3];
	logic        qsat;
	always_comb begin
		logic [NS-1:0] q;
		logic          neg;
		qsat = 1'b0;
		for (int l = 0; l < 3; l++) begin
			q   = st_q[NS].num[l];
			neg = st_q[NS].val[l][31] != st_q[NS].wneg;
			if (!st_q[NS].do_div) begin
				fin[l] = st_q[NS].val[l];
			end else if (!neg) begin
				if (q[NS-1:31] != '0) begin
					fin[l] = 32'h7fffffff;
					qsat   = 1'b1;
				end else begin
					fin[l] = q[31:0];
				end
			end else begin
				if ((q[NS-1:32] != '0) || (q[31] && (q[30:0] != '0))) begin
					fin[l] = 32'h80000000;
					qsat   = 1'b1;
				end else begin
					fin[l] = 32'(-q[31:0]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_out.valid <= 1'b0;
		end else if (adv) begin
			res_out.valid <= sv_q[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_out.out_x     <= fin[0];
			res_out.out_y     <= fin[1];
			res_out.out_z     <= fin[2];
			res_out.divided   <= st_q[NS].do_div;
			res_out.saturated <= st_q[NS].sat || qsat;
		end
	end
endmodule

// ----- hw/rtl/vertex_transform_persp_divide.sv -----
// Top level of the vertex transform with optional perspective divide.
//
// pt_in carries one point (in_x, in_y, in_z, in_w, signed Q16.16) and the
// apply_divide flag; a transaction completes when valid and ready are high.
// res_out carries out_x, out_y, out_z, divided and saturated.
// cfg writes one 64-bit matrix register per transaction (index 0..7, two
// Q16.16 elements per register); higher indexes are ignored. Always ready.
// Throughput: one point per cycle while res_out accepts. Path from accept to
// res_out valid: two front stages (16 multiplies, then sums), the queue, a
// register capturing the queue head, 48 divider stages (one quotient bit
// per stage) and the output register. The divider length is set by the
// 48-bit scaled dividend.
// Reset loads the identity matrix and empties all stages.
// When res_out stalls, the back pipeline holds; the front keeps accepting
// until the 4-entry queue and the two front stages together hold four
// transactions, then drops ready.
`timescale 1ns / 1ps
module vertex_transform_persp_divide (
	input  logic       clk,
	input  logic       arst_n,
	vtpd_in_if.sink    pt_in,
	vtpd_out_if.source res_out,
	vtpd_cfg_if.sink   cfg
);
	logic                            push;
	vtpd_pkg::vtpd_item_t            push_item;
	logic                            pop;
	logic                            empty;
	vtpd_pkg::vtpd_item_t            head;
	logic [vtpd_pkg::FIFO_CNT_W-1:0] level;

	vtpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pt_in      (pt_in),
		.cfg        (cfg),
		.fifo_level (level),
		.push       (push),
		.push_item  (push_item)
	);

	vtpd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.empty     (empty),
		.head      (head),
		.level     (level)
	);

	vtpd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.head    (head),
		.pop     (pop),
		.res_out (res_out)
	);
endmodule

// ----- sim/tb_vertex_transform_persp_divide.sv -----
// Testbench for the vertex transform with perspective divide: directed and random points, scoreboard check.
`timescale 1ns / 1ps
module tb_vertex_transform_persp_divide;
	localparam int LATENCY = 53;

	typedef enum logic [3:0] {
		REG_R0C01 = 4'd0, REG_R0C23 = 4'd1, REG_R1C01 = 4'd2, REG_R1C23 = 4'd3,
		REG_R2C01 = 4'd4, REG_R2C23 = 4'd5, REG_R3C01 = 4'd6, REG_R3C23 = 4'd7,
		REG_BAD = 4'd8
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] w;
		logic               div;
	} point_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               divided;
		logic               saturated;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #4 clk = ~clk;

	vtpd_in_if  pt_in ();
	vtpd_out_if res_out ();
	vtpd_cfg_if cfg ();

	vertex_transform_persp_divide dut (
		.clk(clk), .arst_n(arst_n), .pt_in(pt_in.sink), .res_out(res_out.source), .cfg(cfg.sink)
	);

	logic [63:0] matrix_regs [8];
	point_t      pending_points [$];
	vertex_t     expected_vertices [$];
	int          mismatches = 0;
	bit          idle_on = 1'b1;
	int          src_hold = 0;
	int          snk_hold = 0;

	function automatic logic signed [63:0] elem(int r, int c);
		logic [63:0] rv;
		rv = matrix_regs[r * 2 + c / 2];
		return (c % 2) ? $signed(rv[63:32]) : $signed(rv[31:0]);
	endfunction

	function automatic logic signed [63:0] clip32(logic signed [63:0] v, ref bit flag);
		if (v > 64'sd2147483647) begin
			flag = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			flag = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic logic signed [63:0] fix_quot(logic signed [63:0] n,
			logic signed [63:0] d, ref bit flag);
		logic [63:0] un, ud, q;
		bit neg;
		neg = (n < 0) != (d < 0);
		un = (n < 0 ? -n : n) << vtpd_pkg::FRAC_BITS;
		ud = d < 0 ? -d : d;
		q = un / ud;
		if (!neg) begin
			if (q > 64'd2147483647) begin
				flag = 1'b1;
				return 64'sd2147483647;
			end
			return $signed(q);
		end
		if (q > 64'd2147483648) begin
			flag = 1'b1;
			return -64'sd2147483648;
		end
		return -$signed(q);
	endfunction

	function automatic vertex_t transform_point(point_t p);
		logic signed [63:0] v [4];
		logic signed [63:0] res [4];
		logic signed [63:0] acc, prod;
		bit sat_xyz, sat_w, sat_q;
		vertex_t o;
		sat_xyz = 0; sat_w = 0; sat_q = 0;
		v[0] = p.x; v[1] = p.y; v[2] = p.z; v[3] = p.w;
		for (int c = 0; c < 4; c++) begin
			acc = 0;
			for (int r = 0; r < 4; r++) begin
				prod = v[r] * elem(r, c);
				acc += prod >>> vtpd_pkg::FRAC_BITS;
			end
			if (c == 3) res[c] = clip32(acc, sat_w);
			else res[c] = clip32(acc, sat_xyz);
		end
		o.divided = 1'b0;
		if (p.div && (res[3] < 0 ? -res[3] : res[3]) > vtpd_pkg::NEAR_ZERO_EPS) begin
			o.divided = 1'b1;
			for (int c = 0; c < 3; c++) res[c] = fix_quot(res[c], res[3], sat_q);
		end
		o.x = res[0][31:0]; o.y = res[1][31:0]; o.z = res[2][31:0];
		o.saturated = sat_xyz || sat_q || (p.div && sat_w);
		return o;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		mismatches++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_in.valid <= 1'b0;
			src_hold <= 0;
		end else if (!pt_in.valid || pt_in.ready) begin
			if (pt_in.valid) expected_vertices.push_back(transform_point({pt_in.in_x,
				pt_in.in_y, pt_in.in_z, pt_in.in_w, pt_in.apply_divide}));
			if (src_hold > 0) begin
				src_hold <= src_hold - 1;
				pt_in.valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				src_hold <= $urandom_range(0, 4);
				pt_in.valid <= 1'b0;
			end else if (pending_points.size() > 0) begin
				point_t p;
				p = pending_points.pop_front();
				pt_in.valid <= 1'b1;
				pt_in.in_x <= p.x; pt_in.in_y <= p.y; pt_in.in_z <= p.z;
				pt_in.in_w <= p.w; pt_in.apply_divide <= p.div;
			end else begin
				pt_in.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_out.ready <= 1'b0;
			snk_hold <= 0;
		end else begin
			if (res_out.valid && res_out.ready) begin
				if (expected_vertices.size() == 0) begin
					report("unexpected transaction", res_out.out_x, 0);
				end else begin
					vertex_t e;
					e = expected_vertices.pop_front();
					if (res_out.out_x !== e.x) report("out_x", res_out.out_x, e.x);
					if (res_out.out_y !== e.y) report("out_y", res_out.out_y, e.y);
					if (res_out.out_z !== e.z) report("out_z", res_out.out_z, e.z);
					if (res_out.divided !== e.divided)
						report("divided", 32'(res_out.divided), 32'(e.divided));
					if (res_out.saturated !== e.saturated)
						report("saturated", 32'(res_out.saturated), 32'(e.saturated));
				end
			end
			if (snk_hold > 0) begin
				snk_hold <= snk_hold - 1;
				res_out.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				snk_hold <= $urandom_range(0, 4);
				res_out.ready <= 1'b0;
			end else begin
				res_out.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [63:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx < REG_BAD) matrix_regs[3'(idx)] = data;
		@(posedge clk);
	endtask

	task automatic drain;
		while (pending_points.size() > 0 || pt_in.valid || expected_vertices.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 5))
			0: return 32'h0001_0000;
			1: return 32'hffff_0000;
			2: return 32'h0;
			3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			4: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 6))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 200) - 100;
			3, 4: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_point(logic [31:0] x, y, z, w, logic d);
		point_t p;
		p.x = x; p.y = y; p.z = z; p.w = w; p.div = d;
		pending_points.push_back(p);
	endtask

	task automatic random_matrix;
		logic [31:0] a, b;
		for (int i = 0; i < 8; i++) begin
			a = rand_elem();
			b = rand_elem();
			write_reg(reg_idx_t'(i), {b, a});
		end
	endtask

	initial begin
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		pt_in.valid = 1'b0;
		pt_in.in_x = '0; pt_in.in_y = '0; pt_in.in_z = '0; pt_in.in_w = '0;
		pt_in.apply_divide = 1'b0;
		res_out.ready = 1'b0;
		matrix_regs[0] = 64'h0000_0000_0001_0000;
		matrix_regs[1] = 64'h0;
		matrix_regs[2] = 64'h0001_0000_0000_0000;
		matrix_regs[3] = 64'h0;
		matrix_regs[4] = 64'h0;
		matrix_regs[5] = 64'h0000_0000_0001_0000;
		matrix_regs[6] = 64'h0;
		matrix_regs[7] = 64'h0001_0000_0000_0000;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity: extremes, near-zero w, divide on/off
		add_point(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0001_0000, 1'b0);
		add_point(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0001_0000, 1'b1);
		add_point(32'h0003_0000, 32'hfffd_0000, 32'h0001_8000, 32'd66, 1'b1);
		add_point(32'h0003_0000, 32'hfffd_0000, 32'h0001_8000, 32'd67, 1'b1);
		add_point(32'h0003_0000, 32'h0002_0000, 32'h0001_0000, -32'sd66, 1'b1);
		add_point(32'h0003_0000, 32'h0002_0000, 32'h0001_0000, -32'sd67, 1'b1);
		add_point(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 32'h0000_0100, 1'b1);
		add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
		add_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
		add_point(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
		drain();

		// max-magnitude matrix: sum saturation, w saturation on and off
		for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), 64'h7fff_ffff_7fff_ffff);
		write_reg(REG_BAD, 64'h0);
		add_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
		add_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
		add_point(32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b1);
		add_point(32'h0000_0001, 32'h0, 32'h0, 32'h0, 1'b1);
		drain();
		for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), 64'h8000_0000_8000_0000);
		write_reg(REG_BAD, 64'hffff_ffff_ffff_ffff);
		add_point(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'hffff_0000, 1'b1);
		add_point(32'h0000_0001, 32'h0, 32'h0, 32'h0, 1'b0);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			random_matrix();
			if (ph == 9) idle_on = 1'b0;
			for (int n = 0; n < 105; n++)
				add_point(rand_coord(), rand_coord(), rand_coord(),
					$urandom_range(0, 3) == 0 ? rand_coord() :
					$urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
					$urandom_range(0, 3) != 0);
			drain();
		end
		if (mismatches == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("== FAIL ==");
		$finish;
	end
endmodule
